// ===== hdl/nmrv_pkg.sv =====
// Shared types and constants for the byte majority voter.
// Used by nmrv_vote_core, nmrv_tally and the top level; no dependencies.
`timescale 1ns / 1ps

package nmrv_pkg;

    localparam int LANES  = 5;   // cores carried on the stream
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 8;   // mismatch counter width
    localparam int NUM_W  = 3;   // width of a core count / vote count

    localparam logic [NUM_W-1:0] CORE_COUNT_RESET = 3'd5;

    typedef logic [BYTE_W-1:0]            byte_t;
    typedef logic [NUM_W-1:0]             num_t;
    typedef logic [LANES-1:0][BYTE_W-1:0] lane_bytes_t;
    typedef logic [LANES-1:0][CNT_W-1:0]  lane_cnt_t;

    // Result of one position's vote
    typedef struct packed {
        byte_t            voted;     // zero when no majority
        logic             ok;        // threshold reached
        logic [LANES-1:0] mismatch;  // enabled core differs from voted byte
    } vote_t;

endpackage

// ===== hdl/nmrv_vote_core.sv =====
// Combinational majority vote over one byte position of all cores.
// Depends on nmrv_pkg.
`timescale 1ns / 1ps

module nmrv_vote_core (
    input  nmrv_pkg::lane_bytes_t bytes,
    input  nmrv_pkg::num_t        core_num,
    output nmrv_pkg::vote_t       vote
);
    import nmrv_pkg::*;

    num_t             thresh;
    logic [LANES-1:0] enabled;
    logic [LANES-1:0] reach;

    // even count needs half plus two, odd count half plus one
    assign thresh = {1'b0, core_num[NUM_W-1:1]} + (core_num[0] ? num_t'(1) : num_t'(2));

    always_comb
    begin
        num_t votes;
        votes   = '0;
        enabled = '0;
        reach   = '0;
        for (int j = 0; j < LANES; j++)
        begin
            enabled[j] = (num_t'(j) < core_num);
        end
        for (int j = 0; j < LANES; j++)
        begin
            votes = '0;
            for (int k = 0; k < LANES; k++)
            begin
                if (enabled[k] && (bytes[k] == bytes[j]))
                begin
                    votes = votes + num_t'(1);
                end
            end
            reach[j] = enabled[j] && (votes >= thresh);
        end
    end

    // take the first core that reaches the threshold
    always_comb
    begin
        logic found;
        found      = 1'b0;
        vote.voted = '0;
        for (int j = 0; j < LANES; j++)
        begin
            if (reach[j] && !found)
            begin
                found      = 1'b1;
                vote.voted = bytes[j];
            end
        end
        vote.ok = found;
        for (int j = 0; j < LANES; j++)
        begin
            vote.mismatch[j] = enabled[j] && (bytes[j] != vote.voted);
        end
    end

endmodule

// ===== hdl/nmrv_tally.sv =====
// Per-core mismatch counters and block failure flag, with result formatting.
// Depends on nmrv_pkg.
`timescale 1ns / 1ps

module nmrv_tally #(
    parameter int BLOCK_BYTES = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  last,
    input  nmrv_pkg::num_t        core_num,
    input  nmrv_pkg::vote_t       vote,
    output logic                  unrecoverable,
    output nmrv_pkg::lane_cnt_t   mismatches
);
    import nmrv_pkg::*;

    localparam logic [CNT_W-1:0] SAT = CNT_W'(BLOCK_BYTES);

    lane_cnt_t cnt_reg;
    lane_cnt_t cnt_next;
    logic      failed_reg;
    logic      failed_next;

    always_comb
    begin
        failed_next = failed_reg | ~vote.ok;
        for (int j = 0; j < LANES; j++)
        begin
            cnt_next[j] = cnt_reg[j];
            if (vote.ok && vote.mismatch[j] && (cnt_reg[j] < SAT))
            begin
                cnt_next[j] = cnt_reg[j] + CNT_W'(1);
            end
            // report only at a recoverable block end; a disabled core reports zero even if
            // it counted earlier in the block under a larger core count
            mismatches[j] = (last && !failed_next && (num_t'(j) < core_num)) ? cnt_next[j] : '0;
        end
        unrecoverable = failed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            failed_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (last)
            begin
                cnt_reg    <= '0;
                failed_reg <= 1'b0;
            end
            else
            begin
                cnt_reg    <= cnt_next;
                failed_reg <= failed_next;
            end
        end
    end

endmodule

// ===== hdl/nmr_byte_majority_voter_unit.sv =====
// Top level of the byte majority voter: stream ports, input and result registers.
// Depends on nmrv_pkg, nmrv_vote_core and nmrv_tally.
`timescale 1ns / 1ps

// Byte-wise majority voter across up to five redundant cores.
//
// Slave stream: one transaction per byte position, carrying the byte from
// every core in s_axis_tdata and the end-of-block mark in s_axis_tlast.
// Master stream: one transaction per input transaction, in order, with the
// voted byte, the per-core mismatch counts (non-zero only on a recoverable
// block end) and the position_ok / block_unrecoverable flags in m_axis_tuser.
// cfg_we / cfg_wdata load core_count; write it only while the block is idle.
//
// From input acceptance to the master side a transaction passes the input
// register, then the vote and counter update in a single pass into the result
// register. One transaction is taken every cycle while the receiver does not
// stall; the rate is set by that single-pass vote stage.
//
// Reset clears both pipeline stages, the mismatch counters and the failure
// flag, and sets core_count to five. When the receiver stalls the result
// register holds, the input register fills, and s_axis_tready drops once
// both stages are full; nothing is dropped.

module nmr_byte_majority_voter_unit #(
    parameter int MAX_CORES   = 5,
    parameter int BLOCK_BYTES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [2:0]  cfg_wdata,     // core_count
    input  logic        cfg_we,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // byte_core0 .. byte_core4, 8 bits each
    input  logic        s_axis_tlast,  // last_position
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // voted_byte, mismatches_core0 .. mismatches_core4
    output logic [1:0]  m_axis_tuser,  // position_ok, block_unrecoverable
    output logic        m_axis_tlast   // block_end
);
    import nmrv_pkg::*;

    localparam int   CORE_LIMIT   = (MAX_CORES < LANES) ? MAX_CORES : LANES;
    localparam num_t CORE_LIMIT_N = NUM_W'(CORE_LIMIT);

    num_t        core_count_reg;
    num_t        core_num;

    logic        in_valid_reg;
    lane_bytes_t in_bytes_reg;
    logic        in_last_reg;

    logic        out_valid_reg;
    logic [47:0] out_data_reg;
    logic [1:0]  out_user_reg;
    logic        out_last_reg;

    logic        advance;
    vote_t       vote;
    logic        unrecoverable;
    lane_cnt_t   mismatches;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_count_reg <= CORE_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            core_count_reg <= cfg_wdata;
        end
    end

    // clamp to the cores actually carried and allowed
    assign core_num = (core_count_reg > CORE_LIMIT_N) ? CORE_LIMIT_N : core_count_reg;

    // advance the input stage into the result register whenever it can move
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_bytes_reg <= s_axis_tdata;
            in_last_reg  <= s_axis_tlast;
        end
    end

    nmrv_vote_core u_vote (
        .bytes    (in_bytes_reg),
        .core_num (core_num),
        .vote     (vote)
    );

    nmrv_tally #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_tally (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .last          (in_last_reg),
        .core_num      (core_num),
        .vote          (vote),
        .unrecoverable (unrecoverable),
        .mismatches    (mismatches)
    );

    // result register: hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {mismatches, vote.voted};
            out_user_reg <= {unrecoverable, vote.ok};
            out_last_reg <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // mismatch counts appear only on a block end
    a_counts_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[47:8] == '0)
        else $error("mismatch counts reported off block end");

    // an unrecoverable block reports no counts
    a_no_counts_when_failed: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[47:8] == '0)
        else $error("mismatch counts reported on unrecoverable block");

    // a position without majority yields zero and marks the block
    a_no_majority: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == '0 && m_axis_tuser[1])
        else $error("failed position not flagged");

    // an empty input stage always takes a transaction
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stage empty but not ready");

    // a stalled result is replaced only after it was taken
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !advance)
        else $error("result overwritten while stalled");

endmodule

// ===== bench/nmr_byte_majority_voter_unit_test.sv =====
// Self-checking bench for nmr_byte_majority_voter_unit: directed vectors, then random blocks.
// Depends on nmrv_pkg and the voter RTL; carries its own model of the vote and the counters.
`timescale 1ns / 1ps

// Stimulus runs in three stages:
//   - a table of directed positions, each row tagged with the core count it
//     needs; rows whose result is obvious carry it typed in, the rest go to
//     the vote model,
//   - one long block with a single faulty core, to drive its counter into
//     saturation while the result side is held off,
//   - sixteen random phases, each at its own core count, made of short
//     blocks that mostly reach a majority, with some noise and some blocks
//     left open across a phase boundary.
// The core count is reloaded only once every expected transaction is back.
// A checker process mirrors both handshakes at the clock edge: it runs the
// vote model on every accepted input transaction and compares every
// accepted output transaction with the oldest expectation, field by field.

module nmr_byte_majority_voter_unit_test;

    import nmrv_pkg::*;

    localparam int MAX_CORES      = 5;
    localparam int BLOCK_BYTES    = 128;
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int IDLE_PERCENT   = 36;
    localparam int SETTLE_CYCLES  = 6;      // result register path is two deep
    localparam int HOLD_CYCLES    = 150;    // long receiver hold-off
    localparam int RANDOM_ITEMS   = 1600;
    localparam int TIMEOUT_CYCLES = 300000;

    // One output transaction, split into its fields
    typedef struct packed {
        byte_t     voted;
        logic      ok;
        logic      block_end;
        logic      unrecoverable;
        lane_cnt_t mismatches;     // core 0 in the low byte
    } vote_result_t;

    // One directed row: core count to run at, the position, and optionally
    // the result typed in
    typedef struct packed {
        num_t         cores;
        lane_bytes_t  bytes;
        logic         last;
        logic         typed;
        vote_result_t result;
    } vector_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic [2:0]  cfg_wdata     = CORE_COUNT_RESET;
    logic        cfg_we        = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Typed-in result travelling alongside the input transaction
    logic         typed_valid  = 1'b0;
    vote_result_t typed_result = '0;

    // Idling control: steady switches idling off on both sides, each bump of
    // hold_seq asks the receiver for one long hold-off
    bit steady   = 1'b0;
    int hold_seq = 0;

    // Vote model state
    num_t              core_setting = CORE_COUNT_RESET;
    logic [CNT_W-1:0]  tally [LANES];
    logic              block_failed = 1'b0;
    vote_result_t      pending_votes [$];
    int                failures = 0;
    int                cycles   = 0;

    nmr_byte_majority_voter_unit #(
        .MAX_CORES   (MAX_CORES),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wdata     (cfg_wdata),
        .cfg_we        (cfg_we),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog: give up once the run has taken far longer than any correct one
    initial
    begin
        while (cycles < TIMEOUT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("nmr_byte_majority_voter_unit_test: errors");
        $finish;
    end

    // Number of cores that actually vote: counts above five are treated as five
    function automatic int enabled_of(input num_t cores);
        return (cores > MAX_CORES) ? MAX_CORES : int'(cores);
    endfunction

    // Agreeing cores needed: one more than half, two more for an even count
    function automatic int threshold_of(input int n);
        return n / 2 + ((n % 2 == 0) ? 2 : 1);
    endfunction

    // Vote one position and advance the per-block counters and failure flag
    function automatic vote_result_t vote_position(input lane_bytes_t b, input logic last);
        vote_result_t r;
        int           n;
        int           votes;
        r = '0;
        n = enabled_of(core_setting);
        for (int j = 0; j < n && !r.ok; j++)
        begin
            votes = 0;
            for (int k = 0; k < n; k++)
                if (b[k] == b[j])
                    votes++;
            if (votes >= threshold_of(n))
            begin
                r.ok    = 1'b1;
                r.voted = b[j];
            end
        end
        if (!r.ok)
            block_failed = 1'b1;
        else
            for (int j = 0; j < n; j++)
                if (b[j] != r.voted && tally[j] < BLOCK_BYTES)
                    tally[j]++;
        r.block_end     = last;
        r.unrecoverable = block_failed;
        for (int j = 0; j < LANES; j++)
            if (last && !block_failed && j < n)
                r.mismatches[j] = tally[j];
        if (last)
        begin
            foreach (tally[j])
                tally[j] = '0;
            block_failed = 1'b0;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    // Checker: everything here is sampled at the edge, before any update of
    // that edge lands, so the order of processes within the step is irrelevant.
    // Push before pop, so even a result leaving in the same step as its input would find its entry.
    always @(posedge clk)
    begin : result_check
        vote_result_t want;
        vote_result_t got;
        if (!rst_n)
        begin
            core_setting = CORE_COUNT_RESET;
            foreach (tally[j])
                tally[j] = '0;
            block_failed = 1'b0;
        end
        else
        begin
            if (cfg_we)
                core_setting = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = vote_position(s_axis_tdata, s_axis_tlast);
                pending_votes.push_back(typed_valid ? typed_result : want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.voted         = m_axis_tdata[7:0];
                got.mismatches    = m_axis_tdata[47:8];
                got.ok            = m_axis_tuser[0];
                got.unrecoverable = m_axis_tuser[1];
                got.block_end     = m_axis_tlast;
                if (pending_votes.size() == 0)
                begin
                    $error("result transaction with no input waiting: voted_byte %0d",
                           got.voted);
                    failures++;
                end
                else
                begin
                    want = pending_votes.pop_front();
                    check_field("voted_byte", want.voted, got.voted);
                    check_field("position_ok", 8'(want.ok), 8'(got.ok));
                    check_field("block_end", 8'(want.block_end), 8'(got.block_end));
                    check_field("block_unrecoverable", 8'(want.unrecoverable),
                                8'(got.unrecoverable));
                    for (int j = 0; j < LANES; j++)
                        check_field($sformatf("mismatches_core%0d", j),
                                    want.mismatches[j], got.mismatches[j]);
                end
            end
        end
    end

    function automatic bit idle_roll();
        return !steady && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    // Receiver: random back-pressure, plus a long hold-off on request that is
    // counted down here, independently of the sender
    initial
    begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= !idle_roll();
        end
    end

    function automatic lane_bytes_t lanes(input byte_t c0, input byte_t c1, input byte_t c2,
                                          input byte_t c3, input byte_t c4);
        return {c4, c3, c2, c1, c0};
    endfunction

    // Typed-in result; every typed row has all mismatch counts at zero
    function automatic vote_result_t outcome(input byte_t voted, input logic ok,
                                             input logic last, input logic unrec);
        vote_result_t r;
        r               = '0;
        r.voted         = voted;
        r.ok            = ok;
        r.block_end     = last;
        r.unrecoverable = unrec;
        return r;
    endfunction

    // Random position for n voting cores. Mostly a common byte with no more
    // corrupted cores than the vote tolerates; some positions get one
    // corruption too many, some are pure noise. Disabled lanes carry junk.
    function automatic lane_bytes_t make_position(input int n);
        lane_bytes_t b;
        byte_t       base;
        int          roll;
        int          spare;
        int          flips;
        base  = byte_t'($urandom);
        roll  = $urandom_range(99);
        spare = (n >= 3) ? n - threshold_of(n) : 0;
        b     = {LANES{base}};
        if (roll < 10)
            for (int i = 0; i < LANES; i++)
                b[i] = byte_t'($urandom);
        else
        begin
            flips = (roll < 20) ? spare + 1 : $urandom_range(spare);
            repeat (flips)
                b[$urandom_range((n > 0) ? n - 1 : 0)] = byte_t'($urandom);
        end
        for (int i = n; i < LANES; i++)
            if ($urandom_range(1))
                b[i] = byte_t'($urandom);
        return b;
    endfunction

    // Offer one input transaction and hold it until it is taken
    task automatic offer_position(input lane_bytes_t b, input logic last, input logic typed,
                                  input vote_result_t result);
        while (idle_roll())
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        typed_valid   <= typed;
        typed_result  <= result;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Drop valid and wait until every expected transaction is back, then let
    // the pipeline settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_votes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_core_count(input num_t cores);
        wait_idle();
        cfg_wdata <= cores;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Block where one core is wrong at every position and the rest agree
    task automatic send_long_block(input int span, input int victim);
        lane_bytes_t b;
        byte_t       base;
        for (int p = 0; p < span; p++)
        begin
            base      = byte_t'($urandom);
            b         = {LANES{base}};
            b[victim] = base ^ byte_t'($urandom_range(1, 255));
            offer_position(b, p == span - 1, 1'b0, '0);
        end
    endtask

    initial
    begin : stimulus
        vector_row_t directed_rows [18];
        num_t        phase_cores [16];
        num_t        cores_now;
        int          enabled;
        int          items;
        int          span;

        // Directed rows: extremes of the bytes, blocks ending with and without
        // a majority, every core count including zero and the oversized ones
        directed_rows = '{
            '{3'd5, lanes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, 1'b1,
              outcome(8'h00, 1'b1, 1'b0, 1'b0)},
            '{3'd5, lanes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1, 1'b1,
              outcome(8'hFF, 1'b1, 1'b1, 1'b0)},
            '{3'd5, lanes(8'hAA, 8'hAA, 8'hAA, 8'h55, 8'h00), 1'b0, 1'b0, '0},
            // all five differ: no majority, block marked
            '{3'd5, lanes(8'h01, 8'h02, 8'h03, 8'h04, 8'h05), 1'b0, 1'b1,
              outcome(8'h00, 1'b0, 1'b0, 1'b1)},
            // unrecoverable block end reports no mismatch counts
            '{3'd5, lanes(8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F), 1'b1, 1'b1,
              outcome(8'h7F, 1'b1, 1'b1, 1'b1)},
            '{3'd5, lanes(8'h10, 8'h20, 8'h10, 8'h20, 8'h10), 1'b0, 1'b0, '0},
            '{3'd5, lanes(8'h33, 8'h33, 8'h34, 8'h34, 8'h33), 1'b1, 1'b0, '0},
            // no voting core at all
            '{3'd0, lanes(8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A), 1'b1, 1'b1,
              outcome(8'h00, 1'b0, 1'b1, 1'b1)},
            // single core: the other lanes are ignored
            '{3'd1, lanes(8'hC3, 8'h00, 8'hFF, 8'h12, 8'h34), 1'b0, 1'b0, '0},
            '{3'd1, lanes(8'h80, 8'h7F, 8'h01, 8'hFE, 8'h00), 1'b1, 1'b1,
              outcome(8'h80, 1'b1, 1'b1, 1'b0)},
            // two cores can never reach the threshold of three
            '{3'd2, lanes(8'h44, 8'h44, 8'h44, 8'h44, 8'h44), 1'b1, 1'b1,
              outcome(8'h00, 1'b0, 1'b1, 1'b1)},
            '{3'd3, lanes(8'h01, 8'h02, 8'h02, 8'hFF, 8'hFF), 1'b0, 1'b0, '0},
            '{3'd3, lanes(8'h09, 8'h09, 8'h08, 8'h00, 8'h00), 1'b1, 1'b0, '0},
            // four cores need all four to agree
            '{3'd4, lanes(8'hE0, 8'hE0, 8'hE0, 8'hE1, 8'hE0), 1'b1, 1'b1,
              outcome(8'h00, 1'b0, 1'b1, 1'b1)},
            '{3'd4, lanes(8'h5D, 8'h5D, 8'h5D, 8'h5D, 8'h00), 1'b1, 1'b1,
              outcome(8'h5D, 1'b1, 1'b1, 1'b0)},
            // oversized counts behave as five; this block spans both writes
            '{3'd6, lanes(8'hAB, 8'hAB, 8'hCD, 8'hCD, 8'hAB), 1'b0, 1'b0, '0},
            '{3'd7, lanes(8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF), 1'b1, 1'b0, '0},
            '{3'd5, lanes(8'h96, 8'h69, 8'h96, 8'h69, 8'h96), 1'b1, 1'b0, '0}
        };
        phase_cores = '{3'd5, 3'd3, 3'd0, 3'd5, 3'd4, 3'd1, 3'd5, 3'd7,
                        3'd2, 3'd5, 3'd3, 3'd6, 3'd5, 3'd4, 3'd5, 3'd3};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cores_now = CORE_COUNT_RESET;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].cores != cores_now)
            begin
                load_core_count(directed_rows[i].cores);
                cores_now = directed_rows[i].cores;
            end
            offer_position(directed_rows[i].bytes, directed_rows[i].last,
                           directed_rows[i].typed, directed_rows[i].result);
        end

        // Long block past the counter limit, with the receiver held off so
        // the pipeline fills and the input side stalls
        load_core_count(3'd5);
        hold_seq <= hold_seq + 1;
        send_long_block(BLOCK_BYTES + 12, LANES - 1);

        foreach (phase_cores[i])
        begin
            load_core_count(phase_cores[i]);
            enabled = enabled_of(phase_cores[i]);
            steady <= (i == 2);
            if (i == 1)
                hold_seq <= hold_seq + 1;
            items = 0;
            if ((enabled == 3 || enabled == 5) && $urandom_range(3) == 0)
            begin
                span = $urandom_range(BLOCK_BYTES + 1, BLOCK_BYTES + 32);
                send_long_block(span, $urandom_range(enabled - 1));
                items += span;
            end
            while (items < RANDOM_ITEMS / $size(phase_cores))
            begin
                // one block in ten runs on into the next
                span = $urandom_range(1, 12);
                for (int p = 0; p < span; p++)
                    offer_position(make_position(enabled),
                                   p == span - 1 && $urandom_range(9) != 0, 1'b0, '0);
                items += span;
            end
        end

        wait_idle();
        if (failures == 0)
            $display("nmr_byte_majority_voter_unit_test: clean");
        else
            $display("nmr_byte_majority_voter_unit_test: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/nmrv_pkg.sv
hdl/nmrv_vote_core.sv
hdl/nmrv_tally.sv
hdl/nmr_byte_majority_voter_unit.sv
bench/nmr_byte_majority_voter_unit_test.sv
